@@ rtl/core/rsc_pkg.sv @@
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared constants, types and the sine table generator for the rotate
// source coordinate block.
// ----------------------------------------------------------------------------
package rsc_pkg;

   localparam int FRAC_BITS      = 8;
   localparam int TRIG_FRAC_BITS = 14;

   localparam int DIM_W    = 13;                        // width / height registers
   localparam int ANGLE_W  = 9;
   localparam int CHCNT_W  = 3;
   localparam int COORD_IN_W = 12;                      // dest_x, dest_y
   localparam int CHAN_W   = 2;
   localparam int OUT_W    = 22;                        // source_x, source_y
   localparam int INDEX_W  = 26;

   localparam int TRIG_W   = TRIG_FRAC_BITS + 2;        // signed, covers +-1.0
   localparam int TAB_W    = TRIG_FRAC_BITS + 1;        // unsigned first quadrant
   localparam int TAB_LAST = 90;
   localparam int TAB_IDX_W = 7;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_DEGREES = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 2'd3;

   localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd480;
   localparam logic [ANGLE_W-1:0] ANGLE_RESET  = 9'd0;
   localparam logic [CHCNT_W-1:0] CHCNT_RESET  = 3'd1;

   localparam logic [63:0] PI_Q30 = 64'd3373259426;
   localparam longint      ONE_Q30 = 64'sd1073741824;

   // per-stage advance strobes of the pipeline
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } rsc_adv_type;

   // unsigned quotient by shift and subtract
   function automatic logic [63:0] udiv64(input logic [63:0] num,
                                          input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] rem;
      q   = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem  = rem - {1'b0, den};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // sin(d degrees), d in 0..90, Taylor series in Q30 then rounded half up
   // to TRIG_FRAC_BITS. Only evaluated at elaboration.
   function automatic logic [TAB_W-1:0] sin_q_entry(input int unsigned d);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] div;
      logic [63:0] r;
      longint      sum;
      x    = udiv64(64'(d) * PI_Q30 + 64'd90, 64'd180);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 12; k++) begin
         div  = 64'((2 * k) * (2 * k + 1));
         term = udiv64((term * x2) >> 30, div);
         if ((k & 1) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > ONE_Q30) begin
         sum = ONE_Q30;
      end
      r = 64'(sum + (longint'(1) << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
      return r[TAB_W-1:0];
   endfunction

endpackage

@@ rtl/core/rotate_source_coordinate.sv @@
// ----------------------------------------------------------------------------
// rotate_source_coordinate
// Inverse-mapping address generator for rotating an image about its center:
// per destination pixel gives the source coordinate, an inside flag and the
// destination byte index.
//
//   channel  direction  handshake               payload
//   req      in         req_tvalid/req_tready   dest_x, dest_y, channel
//   rsp      out        rsp_tvalid/rsp_tready   source_x, source_y, inside_res,
//                                               dest_index
//   csr      in         csr_we                  image_width, image_height,
//                                               angle_degrees, channel_count
//
// One pixel per clock unless rsp stalls; stages: trig lookup, four multipliers,
// rotation sums, round/offset/saturate (the last stage is the output register).
// Reset clears the stage valid bits and loads the register defaults.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles are absorbed and a stalled rsp holds every stage without loss.
// ----------------------------------------------------------------------------
module rotate_source_coordinate
   import rsc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // dest_x[11:0], dest_y[23:12], channel[25:24]

   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [71:0]          rsp_tdata,   // source_x[21:0], source_y[43:22],
                                             // inside_res[44], dest_index[70:45]

   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   localparam int DX_W   = DIM_W + FRAC_BITS + 1;        // signed offset from center
   localparam int MID_W  = DIM_W + FRAC_BITS - 1;
   localparam int PROD_W = DX_W + TRIG_W;
   localparam int ACC_W  = PROD_W + 1;
   localparam int SX_W   = ACC_W - TRIG_FRAC_BITS + 1;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (TRIG_FRAC_BITS - 1);
   localparam logic signed [SX_W-1:0]  OUT_MAX = SX_W'((64'sd1 <<< (OUT_W - 1)) - 1);
   localparam logic signed [SX_W-1:0]  OUT_MIN = -(SX_W'(64'sd1 <<< (OUT_W - 1)));

   // ---------------- configuration registers
   logic [DIM_W-1:0]   width_ff;
   logic [DIM_W-1:0]   height_ff;
   logic [ANGLE_W-1:0] angle_ff;
   logic [CHCNT_W-1:0] chcnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         angle_ff  <= ANGLE_RESET;
         chcnt_ff  <= CHCNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT:  height_ff <= csr_wdata;
            CSR_ANGLE_DEGREES: angle_ff  <= csr_wdata[ANGLE_W-1:0];
            CSR_CHANNEL_COUNT: chcnt_ff  <= csr_wdata[CHCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   rsc_adv_type adv;

   always_comb begin
      adv.s4 = !v4_ff || rsp_tready;
      adv.s3 = !v3_ff || adv.s4;
      adv.s2 = !v2_ff || adv.s3;
      adv.s1 = !v1_ff || adv.s2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv.s1) v1_ff <= req_tvalid;
         if (adv.s2) v2_ff <= v1_ff;
         if (adv.s3) v3_ff <= v2_ff;
         if (adv.s4) v4_ff <= v3_ff;
      end
   end

   assign req_tready = adv.s1;
   assign rsp_tvalid = v4_ff;

   // ---------------- input fields
   logic [COORD_IN_W-1:0] dest_x;
   logic [COORD_IN_W-1:0] dest_y;
   logic [CHAN_W-1:0]     channel;

   assign dest_x  = req_tdata[11:0];
   assign dest_y  = req_tdata[23:12];
   assign channel = req_tdata[25:24];

   // ---------------- stage 1: trig lookup, offsets from center
   logic signed [TRIG_W-1:0] sin_val, cos_val;
   logic signed [TRIG_W-1:0] sin_ff, cos_ff;
   logic [MID_W-1:0]         mid_x, mid_y;
   logic signed [DX_W-1:0]   dx_ff, dx_in, dy_ff, dy_in;

   rsc_trig u_trig (
      .angle_degrees (angle_ff),
      .sin_val       (sin_val),
      .cos_val       (cos_val)
   );

   always_comb begin
      mid_x = {width_ff,  {(FRAC_BITS - 1){1'b0}}};
      mid_y = {height_ff, {(FRAC_BITS - 1){1'b0}}};
      dx_in = $signed(DX_W'({dest_x, {FRAC_BITS{1'b0}}})) - $signed(DX_W'(mid_x));
      dy_in = $signed(DX_W'({dest_y, {FRAC_BITS{1'b0}}})) - $signed(DX_W'(mid_y));
   end

   // ---------------- stage 2: products
   logic signed [PROD_W-1:0] cdx_ff, sdy_ff, sdx_ff, cdy_ff;

   // ---------------- stage 3: rotation sums with rounding bias
   logic signed [ACC_W-1:0] accx_ff, accx_in, accy_ff, accy_in;

   always_comb begin
      accx_in = ACC_W'(cdx_ff) - ACC_W'(sdy_ff) + ROUND_HALF;
      accy_in = ACC_W'(sdx_ff) + ACC_W'(cdy_ff) + ROUND_HALF;
   end

   // ---------------- stage 4: back to pixel grid, bounds, saturation
   logic signed [SX_W-1:0]  sx, sy;
   logic                    in_x, in_y;
   logic [OUT_W-1:0]        srcx_ff, srcx_in, srcy_ff, srcy_in;
   logic                    inside_ff, inside_in;

   always_comb begin
      sx = SX_W'(accx_ff >>> TRIG_FRAC_BITS) + $signed(SX_W'(mid_x));
      sy = SX_W'(accy_ff >>> TRIG_FRAC_BITS) + $signed(SX_W'(mid_y));
      // inclusive bounds on the unsaturated value
      in_x = (sx >= 0) && (sx <= $signed(SX_W'({width_ff,  {FRAC_BITS{1'b0}}})));
      in_y = (sy >= 0) && (sy <= $signed(SX_W'({height_ff, {FRAC_BITS{1'b0}}})));
      inside_in = in_x && in_y;
      priority if (sx > OUT_MAX) srcx_in = OUT_MAX[OUT_W-1:0];
      else if (sx < OUT_MIN)     srcx_in = OUT_MIN[OUT_W-1:0];
      else                       srcx_in = sx[OUT_W-1:0];
      priority if (sy > OUT_MAX) srcy_in = OUT_MAX[OUT_W-1:0];
      else if (sy < OUT_MIN)     srcy_in = OUT_MIN[OUT_W-1:0];
      else                       srcy_in = sy[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         sin_ff <= sin_val;
         cos_ff <= cos_val;
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
      end
      if (adv.s2) begin
         cdx_ff <= PROD_W'(cos_ff) * PROD_W'(dx_ff);
         sdy_ff <= PROD_W'(sin_ff) * PROD_W'(dy_ff);
         sdx_ff <= PROD_W'(sin_ff) * PROD_W'(dx_ff);
         cdy_ff <= PROD_W'(cos_ff) * PROD_W'(dy_ff);
      end
      if (adv.s3) begin
         accx_ff <= accx_in;
         accy_ff <= accy_in;
      end
      if (adv.s4) begin
         srcx_ff   <= srcx_in;
         srcy_ff   <= srcy_in;
         inside_ff <= inside_in;
      end
   end

   // ---------------- destination index
   logic [INDEX_W-1:0] dest_index;

   rsc_index u_index (
      .clock         (clock),
      .adv           (adv),
      .dest_x        (dest_x),
      .dest_y        (dest_y),
      .channel       (channel),
      .image_width   (width_ff),
      .channel_count (chcnt_ff),
      .dest_index    (dest_index)
   );

   assign rsp_tdata = {1'b0, dest_index, inside_ff, srcy_ff, srcx_ff};

endmodule

@@ rtl/core/rsc_trig.sv @@
// ----------------------------------------------------------------------------
// rsc_trig
// Sine and cosine of the inverse rotation angle from a first-quadrant table.
// ----------------------------------------------------------------------------
module rsc_trig
   import rsc_pkg::*;
(
   input  logic [ANGLE_W-1:0]       angle_degrees,
   output logic signed [TRIG_W-1:0] sin_val,
   output logic signed [TRIG_W-1:0] cos_val
);

   typedef struct packed {
      logic [TAB_IDX_W-1:0] idx;
      logic                 neg;
   } quad_type;

   logic [TAB_W-1:0] sin_rom [0:TAB_LAST];

   for (genvar d = 0; d <= TAB_LAST; d++) begin : g_rom
      localparam logic [TAB_W-1:0] ENTRY = sin_q_entry(d);
      assign sin_rom[d] = ENTRY;
   end

   // fold an angle 0..359 onto the first quadrant
   function automatic quad_type fold(input logic [ANGLE_W-1:0] a);
      quad_type q;
      priority if (a <= 9'd90) begin
         q.idx = TAB_IDX_W'(a);
         q.neg = 1'b0;
      end else if (a <= 9'd180) begin
         q.idx = TAB_IDX_W'(9'd180 - a);
         q.neg = 1'b0;
      end else if (a <= 9'd270) begin
         q.idx = TAB_IDX_W'(a - 9'd180);
         q.neg = 1'b1;
      end else begin
         q.idx = TAB_IDX_W'(9'd360 - a);
         q.neg = 1'b1;
      end
      return q;
   endfunction

   logic [ANGLE_W-1:0]       ang_mod;
   logic [ANGLE_W-1:0]       ang_inv;
   logic [ANGLE_W-1:0]       ang_cos;
   quad_type                 q_sin;
   quad_type                 q_cos;
   logic signed [TRIG_W-1:0] mag_sin;
   logic signed [TRIG_W-1:0] mag_cos;

   always_comb begin
      ang_mod = (angle_degrees >= 9'd360) ? angle_degrees - 9'd360 : angle_degrees;
      // negated angle, modulo 360
      ang_inv = (ang_mod == '0) ? '0 : 9'd360 - ang_mod;
      ang_cos = (ang_inv >= 9'd270) ? ang_inv - 9'd270 : ang_inv + 9'd90;
      q_sin   = fold(ang_inv);
      q_cos   = fold(ang_cos);
      mag_sin = TRIG_W'(sin_rom[q_sin.idx]);
      mag_cos = TRIG_W'(sin_rom[q_cos.idx]);
      sin_val = q_sin.neg ? -mag_sin : mag_sin;
      cos_val = q_cos.neg ? -mag_cos : mag_cos;
   end

endmodule

@@ rtl/core/rsc_index.sv @@
// ----------------------------------------------------------------------------
// rsc_index
// Destination byte index ((y*width + x)*channels + channel), four stages,
// modulo 2^26.
// ----------------------------------------------------------------------------
module rsc_index
   import rsc_pkg::*;
(
   input  logic                  clock,
   input  rsc_adv_type           adv,
   input  logic [COORD_IN_W-1:0] dest_x,
   input  logic [COORD_IN_W-1:0] dest_y,
   input  logic [CHAN_W-1:0]     channel,
   input  logic [DIM_W-1:0]      image_width,
   input  logic [CHCNT_W-1:0]    channel_count,
   output logic [INDEX_W-1:0]    dest_index
);

   localparam int YW_W = COORD_IN_W + DIM_W;

   logic [YW_W-1:0]       yw_ff,  yw_in;
   logic [COORD_IN_W-1:0] x1_ff;
   logic [CHAN_W-1:0]     ch1_ff, ch2_ff, ch3_ff;
   logic [INDEX_W-1:0]    row_ff, row_in;
   logic [INDEX_W-1:0]    scl_ff, scl_in;
   logic [INDEX_W-1:0]    idx_ff, idx_in;

   always_comb begin
      yw_in  = dest_y * image_width;
      row_in = INDEX_W'(yw_ff) + INDEX_W'(x1_ff);
      scl_in = INDEX_W'(row_ff * channel_count);
      idx_in = scl_ff + INDEX_W'(ch3_ff);
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         yw_ff  <= yw_in;
         x1_ff  <= dest_x;
         ch1_ff <= channel;
      end
      if (adv.s2) begin
         row_ff <= row_in;
         ch2_ff <= ch1_ff;
      end
      if (adv.s3) begin
         scl_ff <= scl_in;
         ch3_ff <= ch2_ff;
      end
      if (adv.s4) begin
         idx_ff <= idx_in;
      end
   end

   assign dest_index = idx_ff;

endmodule
